### hdl/rsad_pkg.sv
// shared types, codes and constants for the run-length sprite decoder
package rsad_pkg;

   // position ranges
   localparam int MAX_COLUMNS = 4096;
   localparam int MAX_ROWS    = 4096;
   localparam int COL_W       = 13;
   localparam int ROW_W       = 12;
   localparam int CLIP_W      = 14;
   localparam int RCNT_W      = 13;

   // column saturation bounds, one bit wider than the column
   localparam logic signed [CLIP_W-1:0] COL_HI = CLIP_W'(MAX_COLUMNS - 1);
   localparam logic signed [CLIP_W-1:0] COL_LO = CLIP_W'(-MAX_COLUMNS);
   localparam logic [ROW_W-1:0]         ROW_LAST = ROW_W'(MAX_ROWS - 1);

   // command queue between parser and executor
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // stream header codes
   localparam logic [7:0] CODE_ROW_END       = 8'h00;
   localparam logic [7:0] CODE_OPAQUE_MAX    = 8'h7F;
   localparam logic [7:0] CODE_LONG_RUN      = 8'h80;
   localparam logic [7:0] CODE_ALPHA_RUN_MAX = 8'h9F;
   localparam logic [7:0] CODE_LONG_SKIP     = 8'hA0;
   localparam logic [7:0] ALPHA_OPAQUE       = 8'hFF;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_CLIP_LEFT    = 3'd0,
      CSR_CLIP_RIGHT   = 3'd1,
      CSR_ROW_COUNT    = 3'd2,
      CSR_GLOBAL_ALPHA = 3'd3,
      CSR_MIRROR       = 3'd4
   } csr_index_type;

   // parser phases
   typedef enum logic [2:0] {
      PH_HEADER     = 3'd0,
      PH_LONG_COUNT = 3'd1,
      PH_ALPHA      = 3'd2,
      PH_SKIP_COUNT = 3'd3,
      PH_BLUE       = 3'd4,
      PH_GREEN      = 3'd5,
      PH_RED        = 3'd6,
      PH_DONE       = 3'd7
   } phase_type;

   // work handed from parser to executor
   typedef enum logic [2:0] {
      OP_NOP     = 3'd0,
      OP_ROW_END = 3'd1,
      OP_FINISH  = 3'd2,
      OP_MOVE    = 3'd3,
      OP_PIXEL   = 3'd4
   } op_type;

   typedef struct packed {
      op_type           op;
      logic             restart;
      logic [7:0]       amount;
      logic [ROW_W-1:0] row;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic [7:0]       alpha;
   } cmd_type;

   // configuration register set
   typedef struct packed {
      logic signed [CLIP_W-1:0] clip_left;
      logic signed [CLIP_W-1:0] clip_right;
      logic [RCNT_W-1:0]        row_count;
      logic [7:0]               global_alpha;
      logic                     mirror;
   } cfg_type;

endpackage

### hdl/rsad_front.sv
// byte parser: decodes header codes and run bytes into executor commands
module rsad_front import rsad_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [7:0]        stream_byte,
   input  logic              frame_start,
   input  logic [RCNT_W-1:0] row_count,
   input  logic              queue_full,
   output logic              byte_ready,
   output logic              push,
   output cmd_type           push_cmd
);

   phase_type        phase_ff, phase_in;
   logic [7:0]       rem_ff, rem_in;
   logic [7:0]       alpha_ff, alpha_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [7:0]       blue_ff, blue_in;
   logic [7:0]       green_ff, green_in;

   phase_type         phase_eff;
   logic [7:0]        rem_eff;
   logic [7:0]        alpha_eff;
   logic [ROW_W-1:0]  row_eff;
   logic [RCNT_W-1:0] rc;
   logic [RCNT_W-1:0] row_next;
   logic [7:0]        rem_dec;
   logic              take;

   assign byte_ready = !queue_full;
   assign take       = byte_valid && !queue_full;
   assign push       = take;

   // phase register and run state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         rem_ff   <= 8'd0;
         alpha_ff <= ALPHA_OPAQUE;
         row_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         alpha_ff <= alpha_in;
         row_ff   <= row_in;
      end
   end

   // held color bytes of the current pixel
   always_ff @(posedge clock) begin
      if (take) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
      end
   end

   // decode one byte
   always_comb begin
      phase_eff = frame_start ? PH_HEADER : phase_ff;
      rem_eff   = frame_start ? 8'd0 : rem_ff;
      alpha_eff = frame_start ? ALPHA_OPAQUE : alpha_ff;
      row_eff   = frame_start ? '0 : row_ff;
      rc        = (row_count == '0) ? RCNT_W'(1) : row_count;
      row_next  = {1'b0, row_eff} + RCNT_W'(1);
      rem_dec   = (rem_eff != 8'd0) ? rem_eff - 8'd1 : 8'd0;

      phase_in = phase_eff;
      rem_in   = rem_eff;
      alpha_in = alpha_eff;
      row_in   = row_eff;
      blue_in  = blue_ff;
      green_in = green_ff;

      push_cmd         = '0;
      push_cmd.op      = OP_NOP;
      push_cmd.restart = frame_start;
      push_cmd.row     = row_eff;
      push_cmd.blue    = blue_ff;
      push_cmd.green   = green_ff;
      push_cmd.red     = stream_byte;
      push_cmd.alpha   = alpha_eff;

      case (phase_eff)
         PH_HEADER: begin
            if (stream_byte == CODE_ROW_END) begin
               if (row_next >= rc) begin
                  push_cmd.op = OP_FINISH;
                  phase_in    = PH_DONE;
               end else begin
                  push_cmd.op = OP_ROW_END;
                  if (row_eff < ROW_LAST) begin
                     row_in = row_eff + ROW_W'(1);
                  end
               end
            end else if (stream_byte <= CODE_OPAQUE_MAX) begin
               rem_in   = stream_byte;
               alpha_in = ALPHA_OPAQUE;
               phase_in = PH_BLUE;
            end else if (stream_byte == CODE_LONG_RUN) begin
               phase_in = PH_LONG_COUNT;
            end else if (stream_byte <= CODE_ALPHA_RUN_MAX) begin
               rem_in   = stream_byte - CODE_LONG_RUN;
               phase_in = PH_ALPHA;
            end else if (stream_byte == CODE_LONG_SKIP) begin
               phase_in = PH_SKIP_COUNT;
            end else begin
               push_cmd.op     = OP_MOVE;
               push_cmd.amount = stream_byte - CODE_LONG_SKIP;
            end
         end
         PH_LONG_COUNT: begin
            rem_in   = stream_byte;
            phase_in = PH_ALPHA;
         end
         PH_ALPHA: begin
            alpha_in = stream_byte;
            phase_in = (rem_eff != 8'd0) ? PH_BLUE : PH_HEADER;
         end
         PH_SKIP_COUNT: begin
            push_cmd.op     = OP_MOVE;
            push_cmd.amount = stream_byte;
            phase_in        = PH_HEADER;
         end
         PH_BLUE: begin
            blue_in  = stream_byte;
            phase_in = PH_GREEN;
         end
         PH_GREEN: begin
            green_in = stream_byte;
            phase_in = PH_RED;
         end
         PH_RED: begin
            push_cmd.op = OP_PIXEL;
            rem_in      = rem_dec;
            phase_in    = (rem_dec != 8'd0) ? PH_BLUE : PH_HEADER;
         end
         default: begin
            // finished sprite: bytes are dropped until the next frame start
            phase_in = PH_DONE;
         end
      endcase
   end

endmodule

### hdl/rsad_queue.sv
// small command queue between parser and executor
module rsad_queue import rsad_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/rsad_back.sv
// executor: column tracking, clipping, weight and the result register
module rsad_back import rsad_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   output logic        rsp_tuser
);

   logic signed [COL_W-1:0] col_ff, col_in;
   logic                    valid_ff, valid_in;
   logic [63:0]             data_ff, data_in;
   logic                    kind_ff, kind_in;

   logic signed [COL_W-1:0]  col_base;
   logic signed [CLIP_W-1:0] col_wide;
   logic signed [CLIP_W-1:0] step;
   logic signed [CLIP_W-1:0] col_sum;
   logic signed [COL_W-1:0]  col_sat;
   logic [7:0]               move_n;
   logic                     visible;
   logic [15:0]              product;
   logic [7:0]               weight;
   logic                     plain;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign cmd_pop    = cmd_valid && (!valid_ff || rsp_tready);

   // column arithmetic, clip test and weight
   always_comb begin
      col_base = cmd.restart ? '0 : col_ff;
      col_wide = CLIP_W'(col_base);
      move_n   = (cmd.op == OP_PIXEL) ? 8'd1 : cmd.amount;
      step     = CLIP_W'({1'b0, move_n});
      col_sum  = cfg.mirror ? col_wide - step : col_wide + step;
      if (col_sum > COL_HI) begin
         col_sat = COL_HI[COL_W-1:0];
      end else if (col_sum < COL_LO) begin
         col_sat = COL_LO[COL_W-1:0];
      end else begin
         col_sat = col_sum[COL_W-1:0];
      end
      visible = (col_wide >= cfg.clip_left) && (col_wide < cfg.clip_right);
      product = cmd.alpha * cfg.global_alpha;
      weight  = product[15:8];
      plain   = (cmd.alpha == ALPHA_OPAQUE) && (cfg.global_alpha == ALPHA_OPAQUE);
   end

   // command execution and result loading
   always_comb begin
      col_in   = col_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      kind_in  = kind_ff;
      if (cmd_pop) begin
         col_in = col_base;
         case (cmd.op)
            OP_ROW_END: begin
               col_in = '0;
            end
            OP_FINISH: begin
               valid_in = 1'b1;
               kind_in  = 1'b1;
               data_in  = {39'd0, cmd.row, col_base};
            end
            OP_MOVE: begin
               col_in = col_sat;
            end
            OP_PIXEL: begin
               col_in = col_sat;
               if (visible && (cfg.global_alpha != 8'd0)) begin
                  valid_in = 1'b1;
                  kind_in  = 1'b0;
                  data_in  = {6'd0, plain, weight, cmd.red, cmd.green, cmd.blue,
                              cmd.row, col_base};
               end
            end
            default: begin
               col_in = col_base;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
   end

endmodule

### hdl/rle_sprite_alpha_decoder_unit.sv
// top level: configuration registers, parser, command queue and executor
// a byte that makes a result passes a queue entry and then the result register
// before it shows on rsp, when the queue is empty and the result register is free
// throughput: one stream byte per cycle while the queue is not full, set by the
// one-byte parser step and the executor; a stalled result port backs up into the queue
// reset: synchronous, active high; clears parse state, queue, position and
// configuration registers to their defaults
module rle_sprite_alpha_decoder_unit import rsad_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // stream input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tuser,   // [0] frame_start
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [12:0] column, [24:13] row, [32:25] blue,
                                    // [40:33] green, [48:41] red, [56:49] weight,
                                    // [57] plain_copy, [63:58] zero
   output logic        rsp_tuser,   // [0] kind
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full;
   logic    q_not_empty;
   logic    q_push;
   logic    q_pop;
   cmd_type push_cmd;
   cmd_type head_cmd;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CLIP_LEFT:    cfg_in.clip_left    = csr_data;
            CSR_CLIP_RIGHT:   cfg_in.clip_right   = csr_data;
            CSR_ROW_COUNT:    cfg_in.row_count    = csr_data[RCNT_W-1:0];
            CSR_GLOBAL_ALPHA: cfg_in.global_alpha = csr_data[7:0];
            CSR_MIRROR:       cfg_in.mirror       = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_left    <= '0;
         cfg_ff.clip_right   <= CLIP_W'(MAX_COLUMNS);
         cfg_ff.row_count    <= RCNT_W'(1);
         cfg_ff.global_alpha <= ALPHA_OPAQUE;
         cfg_ff.mirror       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // parser
   rsad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .stream_byte (req_tdata),
      .frame_start (req_tuser),
      .row_count   (cfg_ff.row_count),
      .queue_full  (q_full),
      .byte_ready  (req_tready),
      .push        (q_push),
      .push_cmd    (push_cmd)
   );

   // command queue
   rsad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // executor
   rsad_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_valid  (q_not_empty),
      .cmd        (head_cmd),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### tb/sv/rle_sprite_alpha_decoder_unit_tb.sv
// self-checking testbench for the run-length sprite decoder: directed table, then random sprites
module rle_sprite_alpha_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rsad_pkg::*;

   localparam int PHASE_ITEMS   = 100;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 600000;

   // one decoded output: pixel write or sprite finished marker
   typedef struct packed {
      logic             kind;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic [7:0]       weight;
      logic             plain_copy;
   } sprite_out_type;

   localparam sprite_out_type NO_OUT = '0;

   // one row of the directed stimulus table
   typedef struct {
      logic [7:0]     code;
      logic           fs;
      bit             lit;
      sprite_out_type res;
   } dir_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [7:0] stream_byte
   logic        req_tuser   = 1'b0; // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;          // [12:0] column, [24:13] row, [32:25] blue,
                                    // [40:33] green, [48:41] red, [56:49] weight,
                                    // [57] plain_copy
   logic        rsp_tuser;          // [0] kind
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index   = '0;
   logic [13:0] csr_data    = '0;

   rle_sprite_alpha_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // decoder copy: configuration
   int         cfg_clip_left  = 0;
   int         cfg_clip_right = MAX_COLUMNS;
   int         cfg_rows       = 1;
   int         cfg_alpha      = 255;
   bit         cfg_mirror     = 1'b0;

   // decoder copy: parse state and position
   phase_type  parse_at  = PH_HEADER;
   int         run_left  = 0;
   int         run_alpha = 255;
   int         col_pos   = 0;
   int         row_pos   = 0;
   logic [7:0] held_b    = '0;
   logic [7:0] held_g    = '0;

   sprite_out_type decoded_q [$];
   int             error_count   = 0;
   int             cycle_count   = 0;
   int             phase_items   = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   bit             first_fs      = 1'b0;
   bit             lit_on        = 1'b0;
   sprite_out_type lit_val       = '0;
   dir_row_type    dir_rows [24];

   // column step with saturation at both ends
   function automatic void step_columns(int n);
      int c;
      c = cfg_mirror ? col_pos - n : col_pos + n;
      if (c < -MAX_COLUMNS)
         c = -MAX_COLUMNS;
      if (c > MAX_COLUMNS - 1)
         c = MAX_COLUMNS - 1;
      col_pos = c;
   endfunction

   // advance the decoder copy by one stream byte
   task automatic decode_byte(input logic [7:0] b, input logic fs, output bit got,
                              output sprite_out_type o);
      int  rc;
      bit  vis;
      got = 1'b0;
      o   = '0;
      // frame start returns position and parse state to reset
      if (fs) begin
         parse_at  = PH_HEADER;
         run_left  = 0;
         run_alpha = 255;
         col_pos   = 0;
         row_pos   = 0;
         held_b    = '0;
         held_g    = '0;
      end
      case (parse_at)
         PH_HEADER: begin
            if (b == CODE_ROW_END) begin
               rc = (cfg_rows == 0) ? 1 : cfg_rows;
               if (row_pos + 1 >= rc) begin
                  o.kind   = 1'b1;
                  o.column = COL_W'(col_pos);
                  o.row    = ROW_W'(row_pos);
                  parse_at = PH_DONE;
                  got      = 1'b1;
               end else begin
                  if (row_pos < MAX_ROWS - 1 && row_pos < (1 << ROW_W) - 1)
                     row_pos++;
                  col_pos = 0;
               end
            end else if (b <= CODE_OPAQUE_MAX) begin
               run_left  = int'(b);
               run_alpha = int'(ALPHA_OPAQUE);
               parse_at  = PH_BLUE;
            end else if (b == CODE_LONG_RUN) begin
               parse_at = PH_LONG_COUNT;
            end else if (b <= CODE_ALPHA_RUN_MAX) begin
               run_left = int'(b - CODE_LONG_RUN);
               parse_at = PH_ALPHA;
            end else if (b == CODE_LONG_SKIP) begin
               parse_at = PH_SKIP_COUNT;
            end else begin
               step_columns(int'(b - CODE_LONG_SKIP));
            end
         end
         PH_LONG_COUNT: begin
            run_left = int'(b);
            parse_at = PH_ALPHA;
         end
         PH_ALPHA: begin
            run_alpha = int'(b);
            parse_at  = (run_left != 0) ? PH_BLUE : PH_HEADER;
         end
         PH_SKIP_COUNT: begin
            step_columns(int'(b));
            parse_at = PH_HEADER;
         end
         PH_BLUE: begin
            held_b   = b;
            parse_at = PH_GREEN;
         end
         PH_GREEN: begin
            held_g   = b;
            parse_at = PH_RED;
         end
         PH_RED: begin
            // emit only inside the clip window and with nonzero global alpha
            vis = col_pos >= cfg_clip_left && col_pos < cfg_clip_right;
            if (vis && cfg_alpha != 0) begin
               o.column     = COL_W'(col_pos);
               o.row        = ROW_W'(row_pos);
               o.blue       = held_b;
               o.green      = held_g;
               o.red        = b;
               o.weight     = 8'((run_alpha * cfg_alpha) >> 8);
               o.plain_copy = (run_alpha == ALPHA_OPAQUE && cfg_alpha == ALPHA_OPAQUE);
               got          = 1'b1;
            end
            step_columns(1);
            if (run_left > 0)
               run_left--;
            parse_at = (run_left != 0) ? PH_BLUE : PH_HEADER;
         end
         default: begin
         end
      endcase
   endtask

   function automatic sprite_out_type px(int col, int rw, logic [7:0] b, logic [7:0] g,
                                         logic [7:0] r, logic [7:0] w, logic pc);
      sprite_out_type o;
      o            = '0;
      o.column     = COL_W'(col);
      o.row        = ROW_W'(rw);
      o.blue       = b;
      o.green      = g;
      o.red        = r;
      o.weight     = w;
      o.plain_copy = pc;
      return o;
   endfunction

   function automatic sprite_out_type fin(int col, int rw);
      sprite_out_type o;
      o        = '0;
      o.kind   = 1'b1;
      o.column = COL_W'(col);
      o.row    = ROW_W'(rw);
      return o;
   endfunction

   function automatic int run_len(int max_len);
      return ($urandom_range(0, 15) == 0) ? int'($urandom_range(1, max_len))
                                          : int'($urandom_range(1, 3));
   endfunction

   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return ALPHA_OPAQUE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one stream transfer; called and returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic fs, input bit counted);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= fs;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (counted)
         phase_items++;
   endtask

   // sprite byte, frame start on the first one
   task automatic put(input logic [7:0] b);
      send_byte(b, first_fs, 1'b1);
      first_fs = 1'b0;
   endtask

   task automatic put_pixels(input int n);
      repeat (n) begin
         put(8'($urandom_range(0, 255)));
         put(8'($urandom_range(0, 255)));
         put(8'($urandom_range(0, 255)));
      end
   endtask

   // well-formed sprite, or one cut short when broken is set
   task automatic gen_sprite(input bit broken, input bit far);
      int rows;
      int n;
      int sel;
      rows     = (cfg_rows == 0) ? 1 : cfg_rows;
      if (broken)
         rows = $urandom_range(1, rows);
      first_fs = 1'b1;
      for (int r = 0; r < rows; r++) begin
         // long skips that drive the column into saturation
         if (far && r == 0) begin
            repeat (17) begin
               put(CODE_LONG_SKIP);
               put(8'hFF);
            end
            put(8'h02);
            put_pixels(2);
         end
         repeat ($urandom_range(0, 3)) begin
            sel = $urandom_range(0, 9);
            if (sel <= 2) begin
               n = run_len(int'(CODE_OPAQUE_MAX));
               put(8'(n));
               put_pixels(n);
            end else if (sel <= 4) begin
               n = run_len(int'(CODE_ALPHA_RUN_MAX - CODE_LONG_RUN));
               put(CODE_LONG_RUN + 8'(n));
               put(pick_alpha());
               put_pixels(n);
            end else if (sel == 5) begin
               n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 3);
               put(CODE_LONG_RUN);
               put(8'(n));
               put(pick_alpha());
               put_pixels(n);
            end else if (sel <= 7) begin
               put(CODE_LONG_SKIP + 8'($urandom_range(1, 95)));
            end else begin
               put(CODE_LONG_SKIP);
               put(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20))
                                               : 8'($urandom_range(0, 255)));
            end
         end
         if (broken && r == rows - 1)
            repeat ($urandom_range(0, 5)) put(8'($urandom_range(0, 255)));
         else
            put(CODE_ROW_END);
      end
   endtask

   // let every expected output arrive, then let the pipeline empty
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register transfer, mirrored into the decoder copy on acceptance
   task automatic write_reg(input csr_index_type idx, input logic [13:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CLIP_LEFT:    cfg_clip_left  = int'($signed(value));
         CSR_CLIP_RIGHT:   cfg_clip_right = int'($signed(value));
         CSR_ROW_COUNT:    cfg_rows       = int'(value[RCNT_W-1:0]);
         CSR_GLOBAL_ALPHA: cfg_alpha      = int'(value[7:0]);
         CSR_MIRROR:       cfg_mirror     = value[0];
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   task automatic apply_setting(input int left, input int right, input int rows,
                                input int alpha, input bit mir);
      drain_outputs();
      write_reg(CSR_CLIP_LEFT, CLIP_W'(left));
      write_reg(CSR_CLIP_RIGHT, CLIP_W'(right));
      write_reg(CSR_ROW_COUNT, 14'(rows));
      write_reg(CSR_GLOBAL_ALPHA, 14'(alpha));
      write_reg(CSR_MIRROR, 14'(mir));
      csr_valid <= 1'b0;
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // predict on accepted input, check accepted output
   always @(posedge clock) begin : monitor
      bit             got;
      sprite_out_type pred;
      sprite_out_type want;
      sprite_out_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tuser, got, pred);
            if (lit_on)
               decoded_q.push_back(lit_val);
            else if (got)
               decoded_q.push_back(pred);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.kind       = rsp_tuser;
            seen.column     = rsp_tdata[12:0];
            seen.row        = rsp_tdata[24:13];
            seen.blue       = rsp_tdata[32:25];
            seen.green      = rsp_tdata[40:33];
            seen.red        = rsp_tdata[48:41];
            seen.weight     = rsp_tdata[56:49];
            seen.plain_copy = rsp_tdata[57];
            if (decoded_q.size() == 0) begin
               $error("output transfer with none expected: kind %0d column %0d row %0d",
                      seen.kind, $signed(seen.column), seen.row);
               error_count++;
            end else begin
               want = decoded_q.pop_front();
               if (want.kind !== seen.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, seen.kind);
                  error_count++;
               end
               if (want.column !== seen.column) begin
                  $error("column: expected %0d, got %0d", $signed(want.column),
                         $signed(seen.column));
                  error_count++;
               end
               if (want.row !== seen.row) begin
                  $error("row: expected %0d, got %0d", want.row, seen.row);
                  error_count++;
               end
               if (want.blue !== seen.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, seen.blue);
                  error_count++;
               end
               if (want.green !== seen.green) begin
                  $error("green: expected %0d, got %0d", want.green, seen.green);
                  error_count++;
               end
               if (want.red !== seen.red) begin
                  $error("red: expected %0d, got %0d", want.red, seen.red);
                  error_count++;
               end
               if (want.weight !== seen.weight) begin
                  $error("weight: expected %0d, got %0d", want.weight, seen.weight);
                  error_count++;
               end
               if (want.plain_copy !== seen.plain_copy) begin
                  $error("plain_copy: expected %0d, got %0d", want.plain_copy,
                         seen.plain_copy);
                  error_count++;
               end
            end
         end
      end
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rle_sprite_alpha_decoder_unit regression: fail");
      $finish;
   end

   initial begin : stimulus
      int  left;
      int  sel;
      bit  far;
      // directed table, default configuration after reset
      dir_rows = '{
         '{8'h01, 1'b1, 1'b0, NO_OUT},   // opaque run of one pixel
         '{8'h00, 1'b0, 1'b0, NO_OUT},
         '{8'hFF, 1'b0, 1'b0, NO_OUT},
         '{8'h80, 1'b0, 1'b1, px(0, 0, 8'h00, 8'hFF, 8'h80, 8'hFE, 1'b1)},
         '{8'h00, 1'b0, 1'b1, fin(1, 0)}, // last row ends the sprite
         '{8'h55, 1'b0, 1'b0, NO_OUT},   // ignored after finish
         '{8'h80, 1'b1, 1'b0, NO_OUT},   // long run with zero count
         '{8'h00, 1'b0, 1'b0, NO_OUT},
         '{8'h40, 1'b0, 1'b0, NO_OUT},
         '{8'h9F, 1'b0, 1'b0, NO_OUT},   // longest short alpha run
         '{8'h01, 1'b0, 1'b0, NO_OUT},
         '{8'h12, 1'b0, 1'b0, NO_OUT},
         '{8'h34, 1'b0, 1'b0, NO_OUT},
         '{8'h56, 1'b0, 1'b1, px(0, 0, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0)},
         '{8'hA0, 1'b1, 1'b0, NO_OUT},   // frame start in the middle of a run
         '{8'hFF, 1'b0, 1'b0, NO_OUT},
         '{8'hA1, 1'b0, 1'b0, NO_OUT},
         '{8'hFF, 1'b0, 1'b0, NO_OUT},
         '{8'h7F, 1'b0, 1'b0, NO_OUT},
         '{8'hAA, 1'b0, 1'b0, NO_OUT},
         '{8'hBB, 1'b0, 1'b0, NO_OUT},
         '{8'hCC, 1'b0, 1'b0, NO_OUT},
         '{8'h00, 1'b1, 1'b1, fin(0, 0)}, // frame start cuts the long run short
         '{8'h00, 1'b0, 1'b0, NO_OUT}
      };
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset         <= 1'b0;
      send_idle_pct = 32;
      recv_idle_pct = 87;
      foreach (dir_rows[i]) begin
         lit_on  = dir_rows[i].lit;
         lit_val = dir_rows[i].res;
         send_byte(dir_rows[i].code, dir_rows[i].fs, 1'b0);
      end
      lit_on = 1'b0;

      // random sprites over a series of settings
      for (int p = 0; p < 9; p++) begin
         case (p / 3)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (p)
            0: apply_setting(-MAX_COLUMNS, MAX_COLUMNS, 3, 255, 1'b0);
            1: apply_setting(-30, 3, 2, 128, 1'b1);
            2: apply_setting(10, 5, 1, 255, 1'b0);     // crossed clip bounds
            3: apply_setting(-8, 40, 0, 0, 1'b0);      // zero rows and zero alpha
            4: apply_setting(-MAX_COLUMNS, MAX_COLUMNS, 4, 1, 1'b1);
            7: apply_setting(0, MAX_COLUMNS, 1, 255, 1'b0);
            default: begin
               left = int'($urandom_range(0, 80)) - 40;
               apply_setting(left, left + int'($urandom_range(0, 60)) - 10,
                             int'($urandom_range(1, 5)), int'(pick_alpha()),
                             1'($urandom_range(0, 1)));
            end
         endcase
         phase_items = 0;
         far         = (p == 0 || p == 4);
         while (phase_items < PHASE_ITEMS) begin
            sel = $urandom_range(0, 15);
            if (sel == 0 && !far) begin
               // noise with occasional frame starts
               repeat ($urandom_range(1, 6))
                  send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b1);
            end else if (sel < 3 && !far) begin
               gen_sprite(1'b1, 1'b0);
            end else begin
               gen_sprite(1'b0, far);
               far = 1'b0;
               // trailing bytes after the finish are ignored
               if ($urandom_range(0, 3) == 0)
                  repeat ($urandom_range(1, 3))
                     send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
         end
      end

      drain_outputs();
      if (error_count == 0)
         $display("rle_sprite_alpha_decoder_unit regression: pass");
      else
         $display("rle_sprite_alpha_decoder_unit regression: fail");
      $finish;
   end

endmodule
